### design/mbsd_pkg.sv
// Package for the MIPS block scan decoder: shared types, constants and the
// opcode mask/match table used by the classifier. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mbsd_pkg;

    localparam int unsigned TableSize = 117;
    localparam logic [6:0] KindUnknown = 7'd117;
    localparam logic [8:0] HardLimit = 9'd256;

    localparam logic [31:0] MaskRegimm = 32'hfc1f0000;
    localparam logic [31:0] MaskMajor  = 32'hfc000000;
    localparam logic [31:0] MaskCopRs  = 32'hffe0003f;
    localparam logic [31:0] MaskCopBc  = 32'hffff0000;
    localparam logic [31:0] MaskSpec   = 32'hfc00003f;
    localparam logic [31:0] MaskCop2   = 32'hfe00003f;

    localparam logic [5:0] FnJr      = 6'h08;
    localparam logic [5:0] FnJalr    = 6'h09;
    localparam logic [5:0] FnSyscall = 6'h0c;
    localparam logic [5:0] FnBreak   = 6'h0d;

    typedef logic [31:0] t_word;

    // One classified word, passed from the front to the back.
    typedef struct packed {
        logic        new_block;
        logic [31:0] start_pc;
        logic [31:0] word;
        logic [6:0]  kind;
        logic        ender;
    } t_entry;

    function automatic logic [31:0] tbl_mask(input int unsigned idx);
        logic [31:0] m;
        begin
            if (idx < 4) m = MaskRegimm;
            else if (idx < 18) m = MaskMajor;
            else if (idx < 47) begin
                if (idx == 22 || idx == 23 || idx == 33 || idx == 34 ||
                    idx == 39 || idx == 40 || idx == 45 || idx == 46)
                    m = MaskCopBc;
                else
                    m = MaskCopRs;
            end else if (idx < 67) m = MaskMajor;
            else if (idx < 95) m = MaskSpec;
            else m = MaskCop2;
            return m;
        end
    endfunction

    localparam logic [31:0] MatchTable [TableSize] = '{
        32'h04000000, 32'h04010000, 32'h04100000, 32'h04110000,
        32'h08000000, 32'h0c000000, 32'h10000000, 32'h14000000, 32'h18000000,
        32'h1c000000, 32'h20000000, 32'h24000000, 32'h28000000, 32'h2c000000,
        32'h30000000, 32'h34000000, 32'h38000000, 32'h3c000000,
        32'h40000000, 32'h40400000, 32'h40800000, 32'h40c00000, 32'h41000000,
        32'h41010000, 32'h42000001, 32'h42000002, 32'h42000006, 32'h42000008,
        32'h42000010, 32'h44000000, 32'h44400000, 32'h44800000, 32'h44c00000,
        32'h45000000, 32'h45010000, 32'h48000000, 32'h48400000, 32'h48800000,
        32'h48c00000, 32'h49000000, 32'h49010000, 32'h4c000000, 32'h4c400000,
        32'h4c800000, 32'h4cc00000, 32'h4d000000, 32'h4d010000,
        32'h80000000, 32'h84000000, 32'h88000000, 32'h8c000000, 32'h90000000,
        32'h94000000, 32'h98000000, 32'ha0000000, 32'ha4000000, 32'ha8000000,
        32'hac000000, 32'hb8000000, 32'hc0000000, 32'hc4000000, 32'hc8000000,
        32'hcc000000, 32'he0000000, 32'he4000000, 32'he8000000, 32'hec000000,
        32'h00000000, 32'h00000002, 32'h00000003, 32'h00000004, 32'h00000006,
        32'h00000007, 32'h00000008, 32'h00000009, 32'h0000000c, 32'h0000000d,
        32'h00000010, 32'h00000011, 32'h00000012, 32'h00000013, 32'h00000018,
        32'h00000019, 32'h0000001a, 32'h0000001b, 32'h00000020, 32'h00000021,
        32'h00000022, 32'h00000023, 32'h00000024, 32'h00000025, 32'h00000026,
        32'h00000027, 32'h0000002a, 32'h0000002b,
        32'h4a000001, 32'h4a000006, 32'h4a00000c, 32'h4a000010, 32'h4a000011,
        32'h4a000012, 32'h4a000013, 32'h4a000014, 32'h4a000016, 32'h4a00001b,
        32'h4a00001c, 32'h4a00001e, 32'h4a000020, 32'h4a000028, 32'h4a000029,
        32'h4a00002a, 32'h4a00002d, 32'h4a00002e, 32'h4a000030, 32'h4a00003d,
        32'h4a00003e, 32'h4a00003f
    };

endpackage
`default_nettype wire

### design/mbsd_front.sv
// Front end: accepts fetched words, classifies them against the opcode
// table and registers the result. Depends on mbsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbsd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    output logic                o_full,
    input  wire                 i_new_block,
    input  wire  [31:0]         i_start_pc,
    input  wire  [31:0]         i_word,
    output logic                o_valid,
    output mbsd_pkg::t_entry    o_entry,
    input  wire                 i_take
);

    logic [6:0]       kind;
    logic             ender;
    logic             r_valid;
    mbsd_pkg::t_entry r_entry;

    // First match wins, so scan from the top down and let lower indices win.
    always_comb begin
        kind = mbsd_pkg::KindUnknown;
        for (int i = mbsd_pkg::TableSize - 1; i >= 0; i--) begin
            if ((i_word & mbsd_pkg::tbl_mask(i)) == mbsd_pkg::MatchTable[i])
                kind = 7'(i);
        end
    end

    always_comb begin
        ender = 1'b0;
        if (i_word[31:26] >= 6'd1 && i_word[31:26] <= 6'd7)
            ender = 1'b1;
        else if (i_word[31:26] == 6'd0 &&
                 (i_word[5:0] == mbsd_pkg::FnJr || i_word[5:0] == mbsd_pkg::FnJalr ||
                  i_word[5:0] == mbsd_pkg::FnSyscall || i_word[5:0] == mbsd_pkg::FnBreak))
            ender = 1'b1;
    end

    assign o_full  = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && !o_full) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_entry <= '{new_block: i_new_block, start_pc: i_start_pc,
                         word: i_word, kind: kind, ender: ender};
        end
    end

endmodule
`default_nettype wire

### design/mbsd_back.sv
// Back end: tracks block state, builds each result word and holds results
// in a two-entry output queue. Depends on mbsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbsd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  mbsd_pkg::t_entry    i_entry,
    output logic                o_take,
    input  wire  [8:0]          i_limit,
    input  wire                 i_pop,
    output logic                o_empty,
    output logic [31:0]         o_instr_pc,
    output logic [6:0]          o_kind,
    output logic [4:0]          o_src_reg,
    output logic [4:0]          o_tgt_reg,
    output logic [4:0]          o_dst_reg,
    output logic [4:0]          o_shift_amt,
    output logic signed [15:0]  o_immediate,
    output logic [27:0]         o_jump_target,
    output logic                o_is_last,
    output logic [31:0]         o_end_pc
);

    typedef struct packed {
        logic [31:0] pc;
        logic [6:0]  kind;
        logic [31:0] word;
        logic        fields;
        logic        last;
        logic [31:0] end_pc;
    } t_res;

    logic [31:0] r_cur_pc, n_cur_pc;
    logic [8:0]  r_count, n_count;
    logic        r_delay, n_delay;
    logic        r_active, n_active;
    t_res        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        emit;
    t_res        res;
    logic [31:0] pc, pc4;
    logic [8:0]  cnt_base, cnt_inc, lim;
    logic        act, dly;
    logic        push_q, pop_q;

    assign o_take = i_valid && (r_cnt != 2'd2);
    assign lim = (i_limit > mbsd_pkg::HardLimit) ? mbsd_pkg::HardLimit :
                 (i_limit == 9'd0) ? 9'd1 : i_limit;

    always_comb begin
        act = r_active;
        dly = r_delay;
        pc = r_cur_pc;
        cnt_base = r_count;
        if (i_entry.new_block) begin
            act = 1'b1;
            dly = 1'b0;
            pc = i_entry.start_pc;
            cnt_base = 9'd0;
        end
        pc4 = pc + 32'd4;
        cnt_inc = cnt_base + 9'd1;
        emit = act;
        n_active = act;
        n_delay = dly;
        n_cur_pc = pc;
        n_count = cnt_base;
        res = '{pc: pc, kind: i_entry.kind, word: i_entry.word, fields: 1'b1,
                last: 1'b0, end_pc: 32'd0};
        if (act) begin
            priority if (dly) begin
                res.last = 1'b1;
                res.end_pc = pc4;
                n_delay = 1'b0;
                n_active = 1'b0;
                n_cur_pc = pc4;
            end else if (i_entry.kind == mbsd_pkg::KindUnknown) begin
                res.fields = 1'b0;
                res.last = 1'b1;
                res.end_pc = pc;
                n_active = 1'b0;
            end else begin
                n_count = cnt_inc;
                n_cur_pc = pc4;
                if (i_entry.ender) begin
                    n_delay = 1'b1;
                end else if (cnt_inc >= lim) begin
                    res.last = 1'b1;
                    res.end_pc = pc4;
                    n_active = 1'b0;
                end
            end
        end
    end

    assign push_q = o_take && emit;
    assign pop_q  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_pc <= 32'd0;
            r_count <= 9'd0;
            r_delay <= 1'b0;
            r_active <= 1'b0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (o_take) begin
                r_cur_pc <= n_cur_pc;
                r_count <= n_count;
                r_delay <= n_delay;
                r_active <= n_active;
            end
            if (push_q) r_wp <= ~r_wp;
            if (pop_q) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push_q} - {1'b0, pop_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_q) r_q[r_wp] <= res;
    end

    // Fields are zeroed for an unknown word outside a delay slot.
    assign o_empty       = (r_cnt == 2'd0);
    assign o_instr_pc    = r_q[r_rp].pc;
    assign o_kind        = r_q[r_rp].kind;
    assign o_src_reg     = r_q[r_rp].fields ? r_q[r_rp].word[25:21] : 5'd0;
    assign o_tgt_reg     = r_q[r_rp].fields ? r_q[r_rp].word[20:16] : 5'd0;
    assign o_dst_reg     = r_q[r_rp].fields ? r_q[r_rp].word[15:11] : 5'd0;
    assign o_shift_amt   = r_q[r_rp].fields ? r_q[r_rp].word[10:6] : 5'd0;
    assign o_immediate   = r_q[r_rp].fields ? signed'(r_q[r_rp].word[15:0]) : 16'sd0;
    assign o_jump_target = r_q[r_rp].fields ? {r_q[r_rp].word[25:0], 2'b00} : 28'd0;
    assign o_is_last     = r_q[r_rp].last;
    assign o_end_pc      = r_q[r_rp].end_pc;

endmodule
`default_nettype wire

### design/mips_block_scan_decoder.sv
// Top level of the MIPS basic-block scan decoder: front classifier, back
// block tracker and the block-length register. Depends on mbsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one fetched word per cycle while full is low and returns one decoded word
// for every word inside a block. A word is held in the front classifier register
// until the back end takes it, and is then written to the two-entry result queue.
// Its result is on the output ports once it is in the queue, and it can then be
// popped. Throughput is one word per cycle while results are popped. The input
// reports full only when both queue entries are waiting and the front register
// is holding a word. The block-length register may be written at any time the
// block is idle.
module mips_block_scan_decoder (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  wire                 i_new_block,
    input  wire  [31:0]         i_start_pc,
    input  wire  [31:0]         i_word,
    output logic                empty,
    input  wire                 pop,
    output logic [31:0]         o_instr_pc,
    output logic [6:0]          o_kind,
    output logic [4:0]          o_src_reg,
    output logic [4:0]          o_tgt_reg,
    output logic [4:0]          o_dst_reg,
    output logic [4:0]          o_shift_amt,
    output logic signed [15:0]  o_immediate,
    output logic [27:0]         o_jump_target,
    output logic                o_is_last,
    output logic [31:0]         o_end_pc,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [8:0]          i_cfg_data
);

    logic             f_valid;
    logic             take;
    mbsd_pkg::t_entry entry;
    logic [8:0]       r_max_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= mbsd_pkg::HardLimit;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    mbsd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_new_block(i_new_block), .i_start_pc(i_start_pc), .i_word(i_word),
        .o_valid(f_valid), .o_entry(entry), .i_take(take)
    );

    mbsd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_entry(entry),
        .o_take(take), .i_limit(r_max_len), .i_pop(pop), .o_empty(empty),
        .o_instr_pc(o_instr_pc), .o_kind(o_kind), .o_src_reg(o_src_reg),
        .o_tgt_reg(o_tgt_reg), .o_dst_reg(o_dst_reg), .o_shift_amt(o_shift_amt),
        .o_immediate(o_immediate), .o_jump_target(o_jump_target),
        .o_is_last(o_is_last), .o_end_pc(o_end_pc)
    );

endmodule
`default_nettype wire

### tb/mips_block_scan_decoder_tb.sv
// Self-checking testbench for the MIPS block scan decoder: directed table, then random
// block streams under several block-length settings. Depends on mbsd_pkg and the RTL.
`timescale 1ns / 1ps
module mips_block_scan_decoder_tb;

    typedef struct {
        logic [31:0] pc;
        logic [6:0]  kind;
        logic [4:0]  rs, rt, rd, sa;
        logic [15:0] imm;
        logic [27:0] jt;
        logic        last;
        logic [31:0] end_pc;
    } t_scan_rec;

    typedef struct {
        logic        nb;
        logic [31:0] spc;
        logic [31:0] word;
        bit          known;
        logic [6:0]  kind;
        logic        last;
        logic [31:0] end_pc;
    } t_row;

    localparam int NumKinds = 117;
    localparam logic [6:0] Unknown = mbsd_pkg::KindUnknown;
    localparam int WatchLimit = 3000;

    localparam logic [31:0] OpMatch [NumKinds] = '{
        32'h04000000, 32'h04010000, 32'h04100000, 32'h04110000,
        32'h08000000, 32'h0c000000, 32'h10000000, 32'h14000000, 32'h18000000,
        32'h1c000000, 32'h20000000, 32'h24000000, 32'h28000000, 32'h2c000000,
        32'h30000000, 32'h34000000, 32'h38000000, 32'h3c000000,
        32'h40000000, 32'h40400000, 32'h40800000, 32'h40c00000, 32'h41000000,
        32'h41010000, 32'h42000001, 32'h42000002, 32'h42000006, 32'h42000008,
        32'h42000010, 32'h44000000, 32'h44400000, 32'h44800000, 32'h44c00000,
        32'h45000000, 32'h45010000, 32'h48000000, 32'h48400000, 32'h48800000,
        32'h48c00000, 32'h49000000, 32'h49010000, 32'h4c000000, 32'h4c400000,
        32'h4c800000, 32'h4cc00000, 32'h4d000000, 32'h4d010000,
        32'h80000000, 32'h84000000, 32'h88000000, 32'h8c000000, 32'h90000000,
        32'h94000000, 32'h98000000, 32'ha0000000, 32'ha4000000, 32'ha8000000,
        32'hac000000, 32'hb8000000, 32'hc0000000, 32'hc4000000, 32'hc8000000,
        32'hcc000000, 32'he0000000, 32'he4000000, 32'he8000000, 32'hec000000,
        32'h00000000, 32'h00000002, 32'h00000003, 32'h00000004, 32'h00000006,
        32'h00000007, 32'h00000008, 32'h00000009, 32'h0000000c, 32'h0000000d,
        32'h00000010, 32'h00000011, 32'h00000012, 32'h00000013, 32'h00000018,
        32'h00000019, 32'h0000001a, 32'h0000001b, 32'h00000020, 32'h00000021,
        32'h00000022, 32'h00000023, 32'h00000024, 32'h00000025, 32'h00000026,
        32'h00000027, 32'h0000002a, 32'h0000002b,
        32'h4a000001, 32'h4a000006, 32'h4a00000c, 32'h4a000010, 32'h4a000011,
        32'h4a000012, 32'h4a000013, 32'h4a000014, 32'h4a000016, 32'h4a00001b,
        32'h4a00001c, 32'h4a00001e, 32'h4a000020, 32'h4a000028, 32'h4a000029,
        32'h4a00002a, 32'h4a00002d, 32'h4a00002e, 32'h4a000030, 32'h4a00003d,
        32'h4a00003e, 32'h4a00003f
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_new_block = 1'b0;
    logic [31:0] i_start_pc = '0;
    logic [31:0] i_word = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_instr_pc;
    logic [6:0]  o_kind;
    logic [4:0]  o_src_reg, o_tgt_reg, o_dst_reg, o_shift_amt;
    logic signed [15:0] o_immediate;
    logic [27:0] o_jump_target;
    logic        o_is_last;
    logic [31:0] o_end_pc;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data = '0;

    mips_block_scan_decoder u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the scanner.
    logic [31:0] sh_pc;
    logic [8:0]  sh_count;
    logic        sh_delay;
    logic        sh_active;
    logic [8:0]  sh_max_len;

    t_scan_rec   decoded_q [$];
    int          errors = 0;
    int          stall_pct = 0;
    int          gap_pct = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    function automatic logic [31:0] kind_mask(int idx);
        if (idx < 4) return 32'hfc1f0000;
        if (idx < 18) return 32'hfc000000;
        if (idx < 47) begin
            if (idx inside {22, 23, 33, 34, 39, 40, 45, 46}) return 32'hffff0000;
            return 32'hffe0003f;
        end
        if (idx < 67) return 32'hfc000000;
        if (idx < 95) return 32'hfc00003f;
        return 32'hfe00003f;
    endfunction

    function automatic logic [6:0] classify_word(logic [31:0] w);
        for (int i = 0; i < NumKinds; i++)
            if ((w & kind_mask(i)) == OpMatch[i]) return 7'(i);
        return Unknown;
    endfunction

    function automatic bit is_block_ender(logic [31:0] w);
        logic [5:0] major;
        logic [5:0] fn;
        major = w[31:26];
        fn = w[5:0];
        if (major >= 6'd1 && major <= 6'd7) return 1'b1;
        return major == 6'd0 &&
               (fn == mbsd_pkg::FnJr || fn == mbsd_pkg::FnJalr ||
                fn == mbsd_pkg::FnSyscall || fn == mbsd_pkg::FnBreak);
    endfunction

    // Advances the shadow state by one accepted word; returns whether a word comes out.
    task automatic scan_step(input logic nb, input logic [31:0] spc, input logic [31:0] w,
                             output t_scan_rec r, output bit produced);
        logic [8:0] limit;
        r = '{default: '0};
        produced = 1'b0;
        if (nb) begin
            sh_pc = spc;
            sh_count = '0;
            sh_delay = 1'b0;
            sh_active = 1'b1;
        end
        if (!sh_active) return;
        produced = 1'b1;
        r.pc = sh_pc;
        r.kind = classify_word(w);
        if (sh_delay || r.kind != Unknown) begin
            r.rs = w[25:21];
            r.rt = w[20:16];
            r.rd = w[15:11];
            r.sa = w[10:6];
            r.imm = w[15:0];
            r.jt = {w[25:0], 2'b00};
        end
        if (sh_delay) begin
            r.last = 1'b1;
            r.end_pc = sh_pc + 32'd4;
            sh_delay = 1'b0;
            sh_active = 1'b0;
            sh_pc = sh_pc + 32'd4;
            return;
        end
        if (r.kind == Unknown) begin
            r.last = 1'b1;
            r.end_pc = sh_pc;
            sh_active = 1'b0;
            return;
        end
        sh_count = sh_count + 9'd1;
        sh_pc = sh_pc + 32'd4;
        if (is_block_ender(w)) begin
            sh_delay = 1'b1;
            return;
        end
        limit = (sh_max_len > 9'd256) ? 9'd256 : (sh_max_len == 9'd0 ? 9'd1 : sh_max_len);
        if (sh_count >= limit) begin
            r.last = 1'b1;
            r.end_pc = sh_pc;
            sh_active = 1'b0;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // Pushes one word, working in bursts with random gaps between them.
    task automatic send_word(input logic nb, input logic [31:0] spc, input logic [31:0] w,
                             output t_scan_rec r, output bit produced);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 99) < gap_pct) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_new_block <= nb;
        i_start_pc <= spc;
        i_word <= w;
        do @(posedge i_clk); while (full);
        scan_step(nb, spc, w, r, produced);
        if (produced) decoded_q = {decoded_q, r};
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        // Ignored words leave nothing queued, so give the pipeline time to settle.
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [8:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sh_max_len = v;
    endtask

    function automatic logic [31:0] random_word();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            idx = $urandom_range(0, NumKinds - 1);
            return OpMatch[idx] | ($urandom() & ~kind_mask(idx));
        end
        if (sel < 88) return $urandom();
        // Plain arithmetic words keep blocks running towards the length limit.
        return {6'd0, 20'($urandom()), 6'h21};
    endfunction

    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
        if (i_rst_n && pop && !empty) begin
            if (decoded_q.size() == 0) begin
                report("unexpected word, instr_pc", o_instr_pc, 32'hx);
            end else begin
                t_scan_rec e;
                e = decoded_q.pop_front();
                if (o_instr_pc !== e.pc) report("instr_pc", o_instr_pc, e.pc);
                if (o_kind !== e.kind) report("kind", 32'(o_kind), 32'(e.kind));
                if (o_src_reg !== e.rs) report("src_reg", 32'(o_src_reg), 32'(e.rs));
                if (o_tgt_reg !== e.rt) report("tgt_reg", 32'(o_tgt_reg), 32'(e.rt));
                if (o_dst_reg !== e.rd) report("dst_reg", 32'(o_dst_reg), 32'(e.rd));
                if (o_shift_amt !== e.sa) report("shift_amt", 32'(o_shift_amt), 32'(e.sa));
                if (o_immediate !== e.imm) report("immediate", 32'(o_immediate), 32'(e.imm));
                if (o_jump_target !== e.jt)
                    report("jump_target", 32'(o_jump_target), 32'(e.jt));
                if (o_is_last !== e.last) report("is_last", 32'(o_is_last), 32'(e.last));
                if (o_end_pc !== e.end_pc) report("end_pc", o_end_pc, e.end_pc);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row        rows [$];
        t_scan_rec   r;
        bit          produced;
        int          results;
        logic [8:0]  settings [7];
        rows = '{
            // A word with no open block is dropped.
            '{1'b0, 32'h0, 32'h0, 1'b0, 7'd0, 1'b0, 32'h0},
            '{1'b1, 32'hfffffff8, 32'h00000000, 1'b1, 7'd67, 1'b0, 32'h0},
            '{1'b0, 32'h0, 32'hffffffff, 1'b1, Unknown, 1'b1, 32'hfffffffc},
            '{1'b1, 32'h0, 32'h08000000, 1'b1, 7'd4, 1'b0, 32'h0},
            '{1'b0, 32'h0, 32'hffffffff, 1'b1, Unknown, 1'b1, 32'h8},
            '{1'b1, 32'hfffffffc, 32'h0000000c, 1'b1, 7'd75, 1'b0, 32'h0},
            '{1'b0, 32'h0, 32'h03ffffff, 1'b0, 7'd0, 1'b0, 32'h0},
            '{1'b0, 32'hffffffff, 32'h00000000, 1'b0, 7'd0, 1'b0, 32'h0},
            '{1'b1, 32'h100, 32'h10000000, 1'b1, 7'd6, 1'b0, 32'h0},
            // Opening a block over a pending delay slot abandons it.
            '{1'b1, 32'h200, 32'h8000ffff, 1'b1, 7'd47, 1'b0, 32'h0},
            '{1'b0, 32'h0, 32'h4a00003f, 1'b1, 7'd116, 1'b0, 32'h0},
            '{1'b0, 32'h0, 32'h0000000d, 1'b1, 7'd76, 1'b0, 32'h0},
            '{1'b0, 32'h0, 32'h00008000, 1'b0, 7'd0, 1'b0, 32'h0},
            '{1'b1, 32'h1000, 32'h0c000000, 1'b0, 7'd0, 1'b0, 32'h0},
            '{1'b0, 32'h0, 32'h40000000, 1'b0, 7'd0, 1'b0, 32'h0}
        };
        settings = '{9'd1, 9'd0, 9'd511, 9'd3, 9'd300, 9'd256, 9'd5};
        sh_pc = '0;
        sh_count = '0;
        sh_delay = 1'b0;
        sh_active = 1'b0;
        sh_max_len = 9'd256;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_word(rows[i].nb, rows[i].spc, rows[i].word, r, produced);
            if (rows[i].known && (r.kind !== rows[i].kind || r.last !== rows[i].last ||
                                  r.end_pc !== rows[i].end_pc)) begin
                $display("table row %0d disagrees with the shadow decoder", i);
                errors++;
            end
        end

        for (int ph = 0; ph < $size(settings) + 1; ph++) begin
            write_max_len(ph < $size(settings) ? settings[ph] : 9'($urandom_range(1, 40)));
            stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
            gap_pct = (ph % 4 == 1) ? 0 : $urandom_range(10, 70);
            results = 0;
            while (results < 50) begin
                logic        nb;
                logic [31:0] spc;
                nb = 1'b0;
                spc = $urandom();
                if (!sh_active) begin
                    // Most idle slots open a block; the rest are dropped noise.
                    nb = ($urandom_range(0, 99) < 80);
                    if ($urandom_range(0, 9) == 0) spc = 32'hfffffff0 | (spc & 32'hc);
                end else if ($urandom_range(0, 49) == 0) begin
                    nb = 1'b1;
                end
                send_word(nb, spc, random_word(), r, produced);
                if (produced) results++;
            end
        end

        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
